// File: src/tht_pkg.sv
package tht_pkg;

    // Handle layout: type in the top bits, running index below.
    localparam int IDX_BITS    = 24;
    localparam int TYPE_BITS   = 3;
    localparam int HANDLE_BITS = IDX_BITS + TYPE_BITS;
    localparam int MAX_TYPES   = 2 ** TYPE_BITS;
    localparam int COUNT_BITS  = 9;
    localparam int WORD_BITS   = 32;

    localparam int NUM_TYPES_DEF      = 8;
    localparam int SLOTS_PER_TYPE_DEF = 256;
    localparam int PAYLOAD_BITS_DEF   = 32;

    localparam logic [COUNT_BITS-1:0] MAX_OBJECTS_RST = 9'd256;
    localparam logic [MAX_TYPES-1:0]  TYPE_ENABLE_RST = 8'hFE;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_COUNT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_TYPE  = 2'd3
    } status_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_MAX_OBJECTS = 1'b0,
        REG_TYPE_ENABLE = 1'b1
    } reg_idx_t;

    // Fill every bit below the highest set bit.
    function automatic logic [COUNT_BITS-1:0] smear(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m;
    endfunction

endpackage

// File: src/tht_slot_store.sv
module tht_slot_store #(
    parameter int NT    = 8,
    parameter int SLOTS = 256,
    parameter int EW    = 57,
    localparam int SIW  = $clog2(SLOTS),
    localparam int TW   = $clog2(NT),
    localparam int AW   = TW + SIW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output logic [EW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data,
    input  logic [NT-1:0] clr_req,
    output logic          busy
);

    // entry: {valid, index, payload}, valid in the top bit
    logic [EW-1:0] mem [NT*SLOTS];

    logic [NT-1:0]  pending_reg, pending_next;
    logic           sweep_on_reg, sweep_on_next;
    logic [TW-1:0]  sweep_type_reg, sweep_type_next;
    logic [SIW-1:0] sweep_slot_reg, sweep_slot_next;
    logic [TW-1:0]  pick;
    logic [NT-1:0]  done_mask;
    logic           sweep_last;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [EW-1:0]  mem_wd;

    always_comb
    begin
        pick = '0;
        for (int i = NT - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                pick = TW'(i);
            end
        end
    end

    assign sweep_last = (sweep_slot_reg == SIW'(SLOTS - 1));
    assign busy       = sweep_on_reg | (|pending_reg);

    always_comb
    begin
        sweep_on_next   = sweep_on_reg;
        sweep_type_next = sweep_type_reg;
        sweep_slot_next = sweep_slot_reg;
        done_mask       = '0;
        if (sweep_on_reg)
        begin
            sweep_slot_next = sweep_slot_reg + 1'b1;
            if (sweep_last)
            begin
                sweep_on_next = 1'b0;
                done_mask     = NT'(1) << sweep_type_reg;
            end
        end
        else if (|pending_reg)
        begin
            sweep_on_next   = 1'b1;
            sweep_type_next = pick;
            sweep_slot_next = '0;
        end
        // a new request for the type just finished wins
        pending_next = (pending_reg & ~done_mask) | clr_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // whole store comes up unknown: clear every usable type
            pending_reg    <= {NT{1'b1}} & ~NT'(1);
            sweep_on_reg   <= 1'b0;
            sweep_type_reg <= '0;
            sweep_slot_reg <= '0;
        end
        else
        begin
            pending_reg    <= pending_next;
            sweep_on_reg   <= sweep_on_next;
            sweep_type_reg <= sweep_type_next;
            sweep_slot_reg <= sweep_slot_next;
        end
    end

    always_comb
    begin
        if (sweep_on_reg)
        begin
            mem_we = 1'b1;
            mem_wa = {sweep_type_reg, sweep_slot_reg};
            mem_wd = '0;
        end
        else
        begin
            mem_we = wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/typed_handle_table.sv
// Per-type generational handle table. An item on s_axis (mode in tuser) allocates a handle
// for a payload, finds or removes an object by its full handle, or queries a type's live
// count; each item gives exactly one result item on m_axis (status in tuser). A handle is
// {type[2:0], index[23:0]}; the low index bits pick a slot in the type's table, whose size
// is the smallest power of two covering max_objects, capped at SLOTS_PER_TYPE. Slots live
// in one single-port-read synchronous memory. An accepted item passes from the idle state
// through the check state and the done state to the output register; allocate stays in
// the check state while it skips occupied slots, since each probe is one read of the slot
// memory. A finished result waits in the output register while the next item is taken.
// After reset the slot memory is cleared type by type, and enabling a type through
// type_enable_mask clears that type; s_axis_tready is low meanwhile, while register writes
// are taken as usual. Registers: max_objects at byte address 0, type_enable_mask at byte
// address 4; write them only while idle.
module typed_handle_table #(
    parameter int NUM_TYPES      = tht_pkg::NUM_TYPES_DEF,
    parameter int SLOTS_PER_TYPE = tht_pkg::SLOTS_PER_TYPE_DEF,
    parameter int PAYLOAD_BITS   = tht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: obj_type[2:0], handle[29:3], payload[61:30], zero[63:62]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // s_axis_tuser: mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // m_axis_tdata: result_handle[26:0], found_payload[58:27], live_count[67:59], zero[71:68]
    output logic [71:0] m_axis_tdata,
    // m_axis_tuser: status[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import tht_pkg::*;

    localparam int NT        = (NUM_TYPES < MAX_TYPES) ? NUM_TYPES : MAX_TYPES;
    localparam int TW        = $clog2(NT);
    localparam int SIW       = $clog2(SLOTS_PER_TYPE);
    localparam int AW        = TW + SIW;
    localparam int SW        = (PAYLOAD_BITS < WORD_BITS) ? PAYLOAD_BITS : WORD_BITS;
    localparam int EW        = 1 + IDX_BITS + SW;
    localparam int SLOTS_CAP = (SLOTS_PER_TYPE > 511) ? 511 : SLOTS_PER_TYPE;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DONE  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] max_objects_reg;
    logic [MAX_TYPES-1:0]  type_enable_reg;
    logic [IDX_BITS-1:0]   next_index_reg [NT];
    logic [COUNT_BITS-1:0] live_total_reg [NT];

    mode_t                 mode_reg;
    logic [TYPE_BITS-1:0]  type_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [SW-1:0]         payload_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [SIW-1:0]        probe_cnt_reg;

    status_t               res_status_reg;
    logic [HANDLE_BITS-1:0] res_handle_reg;
    logic [WORD_BITS-1:0]  res_payload_reg;
    logic [COUNT_BITS-1:0] res_live_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [WORD_BITS-1:0]  out_payload_reg;
    logic [COUNT_BITS-1:0] out_live_reg;

    // register port
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;
    logic [MAX_TYPES-1:0]  enable_rise;
    logic [NT-1:0]         clr_req;

    // limit and table mask
    logic [COUNT_BITS-1:0] eff_lim;
    logic [SIW-1:0]        cap_mask;

    // input side
    logic                  in_accept;
    mode_t                 in_mode;
    logic [TYPE_BITS-1:0]  in_obj_type;
    logic [HANDLE_BITS-1:0] in_handle;
    logic [WORD_BITS-1:0]  in_payload;
    logic [TYPE_BITS-1:0]  in_type;
    logic [IDX_BITS-1:0]   in_idx;

    // slot store
    logic [AW-1:0]         rd_addr;
    logic [EW-1:0]         rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;
    logic                  clr_busy;

    // lookup step
    logic [TW-1:0]         tix;
    logic                  t_in_range;
    logic                  t_ok;
    logic [COUNT_BITS-1:0] live_cur;
    logic                  e_valid;
    logic [IDX_BITS-1:0]   e_index;
    logic [SW-1:0]         e_payload;
    logic [IDX_BITS-1:0]   idx_inc;
    logic [AW-1:0]         cur_addr;
    logic [AW-1:0]         nxt_addr;
    logic                  fin;
    logic                  ni_we;
    logic                  live_we;
    status_t               chk_status;
    logic [HANDLE_BITS-1:0] chk_handle;
    logic [WORD_BITS-1:0]  chk_payload;
    logic [COUNT_BITS-1:0] live_new;
    logic                  out_free;

    // ---------------- registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_OBJECTS: prdata = {23'd0, max_objects_reg};
            REG_TYPE_ENABLE: prdata = {24'd0, type_enable_reg};
            default:         prdata = '0;
        endcase
    end

    // type zero never gets a table
    assign enable_rise = (cfg_wr && cfg_idx == REG_TYPE_ENABLE)
                       ? (pwdata[MAX_TYPES-1:0] & ~type_enable_reg & ~MAX_TYPES'(1))
                       : '0;
    assign clr_req = enable_rise[NT-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_objects_reg <= MAX_OBJECTS_RST;
            type_enable_reg <= TYPE_ENABLE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MAX_OBJECTS: max_objects_reg <= pwdata[COUNT_BITS-1:0];
                REG_TYPE_ENABLE: type_enable_reg <= pwdata[MAX_TYPES-1:0];
                default: ;
            endcase
        end
    end

    assign eff_lim  = (max_objects_reg > COUNT_BITS'(SLOTS_CAP)) ? COUNT_BITS'(SLOTS_CAP)
                                                                 : max_objects_reg;
    // eff_lim never exceeds the table, so the smeared value fits in SIW bits
    assign cap_mask = (eff_lim <= COUNT_BITS'(1)) ? '0
                                                  : SIW'(smear(eff_lim - 1'b1));

    // ---------------- input decode ----------------
    assign in_mode     = mode_t'(s_axis_tuser);
    assign in_obj_type = s_axis_tdata[2:0];
    assign in_handle   = s_axis_tdata[29:3];
    assign in_payload  = s_axis_tdata[61:30];
    assign in_type     = (in_mode == MODE_FIND || in_mode == MODE_REMOVE)
                       ? in_handle[HANDLE_BITS-1 -: TYPE_BITS] : in_obj_type;

    always_comb
    begin
        if (in_mode == MODE_ALLOC)
        begin
            in_idx = ({1'b0, in_type} < 4'(NT)) ? next_index_reg[in_type[TW-1:0]] : '0;
        end
        else
        begin
            in_idx = in_handle[IDX_BITS-1:0];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !clr_busy;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // ---------------- slot store ----------------
    tht_slot_store #(
        .NT    (NT),
        .SLOTS (SLOTS_PER_TYPE),
        .EW    (EW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .clr_req (clr_req),
        .busy    (clr_busy)
    );

    // ---------------- lookup / allocate step ----------------
    assign tix        = type_reg[TW-1:0];
    assign t_in_range = {1'b0, type_reg} < 4'(NT);
    assign t_ok       = (type_reg != '0) && t_in_range && type_enable_reg[type_reg];
    assign live_cur   = t_in_range ? live_total_reg[tix] : '0;

    assign e_valid   = rd_data[EW-1];
    assign e_index   = rd_data[EW-2 -: IDX_BITS];
    assign e_payload = rd_data[SW-1:0];

    assign idx_inc  = idx_reg + 1'b1;
    assign cur_addr = {tix, SIW'(idx_reg) & cap_mask};
    assign nxt_addr = {tix, SIW'(idx_inc) & cap_mask};

    always_comb
    begin
        fin         = 1'b0;
        ni_we       = 1'b0;
        live_we     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = cur_addr;
        wr_data     = {1'b1, idx_reg, payload_reg};
        chk_status  = ST_OK;
        chk_handle  = handle_reg;
        chk_payload = '0;
        live_new    = live_cur;
        if (!t_ok)
        begin
            fin        = 1'b1;
            chk_status = ST_BAD_TYPE;
        end
        else
        begin
            unique case (mode_reg)
                MODE_ALLOC:
                begin
                    if (live_cur >= eff_lim)
                    begin
                        fin        = 1'b1;
                        chk_status = ST_FULL;
                    end
                    else
                    begin
                        ni_we = 1'b1;
                        if (!e_valid)
                        begin
                            fin        = 1'b1;
                            wr_en      = 1'b1;
                            live_we    = 1'b1;
                            live_new   = live_cur + 1'b1;
                            chk_handle = {type_reg, idx_reg};
                        end
                        else if (probe_cnt_reg == cap_mask)
                        begin
                            // a whole table probed without a free slot
                            fin        = 1'b1;
                            chk_status = ST_FULL;
                        end
                    end
                end
                MODE_FIND, MODE_REMOVE:
                begin
                    fin = 1'b1;
                    if (e_valid && e_index == idx_reg)
                    begin
                        chk_payload = WORD_BITS'(e_payload);
                        if (mode_reg == MODE_REMOVE)
                        begin
                            wr_en   = 1'b1;
                            wr_data = {1'b0, e_index, e_payload};
                            live_we = 1'b1;
                            if (live_cur != '0)
                            begin
                                live_new = live_cur - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        chk_status = ST_NOT_FOUND;
                    end
                end
                MODE_COUNT:
                begin
                    fin = 1'b1;
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end
        // besides the store's clearing sweep, only the lookup step writes the slot memory
        if (state_reg != S_CHECK)
        begin
            wr_en = 1'b0;
        end
    end

    // a new item reads its slot on accept; a probe reads the next slot
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = {in_type[TW-1:0], SIW'(in_idx) & cap_mask};
        end
        else
        begin
            rd_addr = nxt_addr;
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (fin)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // per-type counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
            begin
                next_index_reg[i] <= '0;
                live_total_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NT; i++)
            begin
                if (clr_req[i])
                begin
                    next_index_reg[i] <= '0;
                    live_total_reg[i] <= '0;
                end
            end
            if (state_reg == S_CHECK)
            begin
                if (ni_we)
                begin
                    next_index_reg[tix] <= idx_inc;
                end
                if (live_we)
                begin
                    live_total_reg[tix] <= live_new;
                end
            end
        end
    end

    // item and result holding registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg      <= in_mode;
            type_reg      <= in_type;
            handle_reg    <= in_handle;
            payload_reg   <= in_payload[SW-1:0];
            idx_reg       <= in_idx;
            probe_cnt_reg <= '0;
        end
        else if (state_reg == S_CHECK)
        begin
            if (fin)
            begin
                res_status_reg  <= chk_status;
                res_handle_reg  <= chk_handle;
                res_payload_reg <= chk_payload;
                res_live_reg    <= live_new;
            end
            else
            begin
                idx_reg       <= idx_inc;
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg  <= res_status_reg;
            out_handle_reg  <= res_handle_reg;
            out_payload_reg <= res_payload_reg;
            out_live_reg    <= res_live_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'd0, out_live_reg, out_payload_reg, out_handle_reg};

endmodule

// File: tb/sv/tb_typed_handle_table.sv
`timescale 1ns / 1ps

module tb_typed_handle_table;
    import tht_pkg::*;

    localparam int SLOTS       = SLOTS_PER_TYPE_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 10000;
    localparam int BATCH_ITEMS = 40;

    typedef struct {
        mode_t                  mode;
        logic [TYPE_BITS-1:0]   otype;
        logic [HANDLE_BITS-1:0] handle;
        logic [WORD_BITS-1:0]   payload;
    } tbl_req_t;

    typedef struct {
        status_t                status;
        logic [HANDLE_BITS-1:0] handle;
        logic [WORD_BITS-1:0]   payload;
        logic [COUNT_BITS-1:0]  count;
    } tbl_rsp_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    typed_handle_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the block's registers and tables
    logic [COUNT_BITS-1:0]  cfg_max_objects = MAX_OBJECTS_RST;
    logic [MAX_TYPES-1:0]   cfg_type_enable = TYPE_ENABLE_RST;
    logic [IDX_BITS-1:0]    next_idx [MAX_TYPES] = '{default: '0};
    logic [COUNT_BITS-1:0]  live_cnt [MAX_TYPES] = '{default: '0};
    bit                     slot_used [MAX_TYPES][SLOTS];
    logic [IDX_BITS-1:0]    slot_idx  [MAX_TYPES][SLOTS];
    logic [WORD_BITS-1:0]   slot_pay  [MAX_TYPES][SLOTS];

    tbl_req_t               pending_reqs [$];
    tbl_rsp_t               results_due [$];
    logic [HANDLE_BITS-1:0] issued_handles [$];
    tbl_req_t               cur_req;
    tbl_rsp_t               head_rsp;

    int  send_idle_pct = 11;
    int  recv_idle_pct = 57;
    bit  hold_req = 1'b0;
    bit  hold_ack = 1'b0;
    int  hold_left = 0;
    int  stall_cycles = 0;
    int  fail_count = 0;
    int  results_checked = 0;
    int  settings_applied = 0;
    int  status_tally [4] = '{default: 0};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic tbl_rsp_t apply_table_op(input tbl_req_t rq);
        tbl_rsp_t              rs;
        logic [TYPE_BITS-1:0]  t;
        logic [IDX_BITS-1:0]   idx;
        logic [COUNT_BITS-1:0] lim;
        int                    cap;
        int                    n;
        int                    s;
        bit                    placed;
        t = (rq.mode == MODE_FIND || rq.mode == MODE_REMOVE) ?
            rq.handle[HANDLE_BITS-1:IDX_BITS] : rq.otype;
        lim = (cfg_max_objects > COUNT_BITS'(SLOTS)) ? COUNT_BITS'(SLOTS) : cfg_max_objects;
        cap = 1;
        while (cap < lim && cap < SLOTS)
            cap = cap * 2;
        rs.status  = ST_OK;
        rs.handle  = rq.handle;
        rs.payload = '0;
        if (t == 0 || !cfg_type_enable[t])
            rs.status = ST_BAD_TYPE;
        else if (rq.mode == MODE_ALLOC)
        begin
            if (live_cnt[t] >= lim)
                rs.status = ST_FULL;
            else
            begin
                // probe forward from the running index, at most one table's worth
                placed = 1'b0;
                for (n = 0; n < cap && !placed; n++)
                begin
                    idx = next_idx[t];
                    s = int'(idx) & (cap - 1);
                    next_idx[t] = idx + 1'b1;
                    if (!slot_used[t][s])
                    begin
                        slot_used[t][s] = 1'b1;
                        slot_idx[t][s]  = idx;
                        slot_pay[t][s]  = rq.payload;
                        live_cnt[t]     = live_cnt[t] + 1'b1;
                        rs.handle       = {t, idx};
                        placed          = 1'b1;
                        issued_handles.push_back(rs.handle);
                        if (issued_handles.size() > 64)
                            void'(issued_handles.pop_front());
                    end
                end
                if (!placed)
                    rs.status = ST_FULL;
            end
        end
        else if (rq.mode == MODE_FIND || rq.mode == MODE_REMOVE)
        begin
            idx = rq.handle[IDX_BITS-1:0];
            s = int'(idx) & (cap - 1);
            if (slot_used[t][s] && slot_idx[t][s] == idx)
            begin
                rs.payload = slot_pay[t][s];
                if (rq.mode == MODE_REMOVE)
                begin
                    slot_used[t][s] = 1'b0;
                    if (live_cnt[t] > 0)
                        live_cnt[t] = live_cnt[t] - 1'b1;
                end
            end
            else
                rs.status = ST_NOT_FOUND;
        end
        rs.count = live_cnt[t];
        return rs;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(apply_table_op(cur_req));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, cur_req.payload, cur_req.handle, cur_req.otype};
                    s_axis_tuser  <= cur_req.mode;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                status_tally[m_axis_tuser]++;
                if (results_due.size() == 0)
                begin
                    $error("unexpected result item: status %0d tdata %h", m_axis_tuser,
                           m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    head_rsp = results_due.pop_front();
                    results_checked++;
                    if (m_axis_tuser !== head_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", head_rsp.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[26:0] !== head_rsp.handle)
                    begin
                        $error("result_handle: expected %h, got %h", head_rsp.handle,
                               m_axis_tdata[26:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[58:27] !== head_rsp.payload)
                    begin
                        $error("found_payload: expected %h, got %h", head_rsp.payload,
                               m_axis_tdata[58:27]);
                        fail_count++;
                    end
                    if (m_axis_tdata[67:59] !== head_rsp.count)
                    begin
                        $error("live_count: expected %0d, got %0d", head_rsp.count,
                               m_axis_tdata[67:59]);
                        fail_count++;
                    end
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("stalled for %0d cycles, %0d results still due", stall_cycles,
                         results_due.size());
                $display("tb_typed_handle_table NOT OK");
                $finish;
            end
        end
    end

    task automatic push_req(input mode_t m, input logic [2:0] ot, input logic [26:0] h,
                            input logic [31:0] p);
        tbl_req_t rq;
        rq.mode    = m;
        rq.otype   = ot;
        rq.handle  = h;
        rq.payload = p;
        pending_reqs.push_back(rq);
    endtask

    // sampled mid-cycle so the sender's updates at the edge have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || results_due.size() != 0);
    endtask

    // write then read back one register over APB
    task automatic set_register(input reg_idx_t r, input logic [31:0] v);
        logic [31:0] want;
        int          t;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write lands on this edge
        if (r == REG_MAX_OBJECTS)
            cfg_max_objects = v[COUNT_BITS-1:0];
        else
        begin
            // a newly enabled type starts from an empty table
            for (t = 1; t < MAX_TYPES; t++)
                if (v[t] && !cfg_type_enable[t])
                begin
                    next_idx[t] = '0;
                    live_cnt[t] = '0;
                    for (int s = 0; s < SLOTS; s++)
                        slot_used[t][s] = 1'b0;
                end
            cfg_type_enable = v[MAX_TYPES-1:0];
        end
        want = (r == REG_MAX_OBJECTS) ? 32'(cfg_max_objects) : 32'(cfg_type_enable);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata reg %0d: expected %h, got %h", r, want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input logic [8:0] max_obj, input logic [7:0] mask);
        wait_drained();
        repeat (4) @(posedge clk);
        set_register(REG_MAX_OBJECTS, 32'(max_obj));
        set_register(REG_TYPE_ENABLE, 32'(mask));
        settings_applied++;
    endtask

    task automatic queue_random_batch(input int n);
        tbl_req_t               rq;
        logic [TYPE_BITS-1:0]   en_types [$];
        logic [HANDLE_BITS-1:0] h;
        int                     i;
        int                     t;
        int                     pick;
        for (t = 1; t < MAX_TYPES; t++)
            if (cfg_type_enable[t])
                en_types.push_back(TYPE_BITS'(t));
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            rq.mode = (pick < 40) ? MODE_ALLOC : (pick < 65) ? MODE_FIND :
                      (pick < 90) ? MODE_REMOVE : MODE_COUNT;
            if (en_types.size() != 0 && $urandom_range(0, 99) < 85)
                rq.otype = en_types[$urandom_range(0, en_types.size() - 1)];
            else
                rq.otype = TYPE_BITS'($urandom_range(0, 7));
            rq.payload = $urandom();
            pick = $urandom_range(0, 99);
            if (issued_handles.size() != 0 && pick < 60)
                h = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
            else if (issued_handles.size() != 0 && pick < 80)
            begin
                // stale handle: same type, one index bit flipped
                h = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
                h[$urandom_range(0, IDX_BITS - 1)] ^= 1'b1;
            end
            else if (pick < 90)
                h = {rq.otype, IDX_BITS'($urandom())};
            else
                h = HANDLE_BITS'($urandom());
            rq.handle = h;
            pending_reqs.push_back(rq);
        end
    endtask

    logic [8:0] max_list  [12] = '{9'd256, 9'd1, 9'd5, 9'd16, 9'd0, 9'd300,
                                  9'd100, 9'd3, 9'd2, 9'd64, 9'd511, 9'd8};
    logic [7:0] mask_list [12] = '{8'hFE, 8'hFF, 8'h55, 8'h00, 8'hAA, 8'hFE,
                                  8'h7F, 8'h81, 8'hFE, 8'hC3, 8'hFF, 8'hFE};

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: invalid types, both payload extremes, hits, stale and removed handles
        push_req(MODE_COUNT,  3'd1, 27'h0,       32'h0);
        push_req(MODE_COUNT,  3'd0, 27'h7FFFFFF, 32'hFFFFFFFF);
        push_req(MODE_ALLOC,  3'd0, 27'h5A5A5A5, 32'h12345678);
        push_req(MODE_ALLOC,  3'd1, 27'h0,       32'h0);
        push_req(MODE_ALLOC,  3'd1, 27'h0,       32'hFFFFFFFF);
        push_req(MODE_ALLOC,  3'd7, 27'h7FFFFFF, 32'hA5A5A5A5);
        push_req(MODE_FIND,   3'd0, {3'd1, 24'd0},   32'h0);
        push_req(MODE_FIND,   3'd7, {3'd1, 24'd1},   32'hFFFFFFFF);
        push_req(MODE_FIND,   3'd1, {3'd1, 24'd256}, 32'h0);
        push_req(MODE_REMOVE, 3'd1, {3'd1, 24'd0},   32'h0);
        push_req(MODE_REMOVE, 3'd1, {3'd1, 24'd0},   32'h0);
        push_req(MODE_FIND,   3'd1, {3'd1, 24'd0},   32'h0);
        push_req(MODE_FIND,   3'd1, 27'h0,       32'h0);
        push_req(MODE_FIND,   3'd1, 27'h7FFFFFF, 32'h0);
        push_req(MODE_REMOVE, 3'd2, 27'h0FFFFFF, 32'h0);
        push_req(MODE_COUNT,  3'd7, 27'h0,       32'h0);
        push_req(MODE_ALLOC,  3'd1, 27'h0,       32'h00000001);
        // limit of one: second allocate reports full
        apply_settings(9'd1, 8'hFE);
        push_req(MODE_ALLOC,  3'd2, 27'h0, 32'h80000000);
        push_req(MODE_ALLOC,  3'd2, 27'h0, 32'h7FFFFFFF);
        push_req(MODE_COUNT,  3'd2, 27'h0, 32'h0);
        push_req(MODE_REMOVE, 3'd2, {3'd2, 24'd0}, 32'h0);
        push_req(MODE_ALLOC,  3'd2, 27'h0, 32'hC0FFEE00);
        // type 2 disabled keeps its count; re-enabling wipes it
        apply_settings(9'd1, 8'hFA);
        push_req(MODE_ALLOC,  3'd2, 27'h0, 32'h0);
        push_req(MODE_FIND,   3'd0, {3'd2, 24'd1}, 32'h0);
        apply_settings(9'd1, 8'hFE);
        push_req(MODE_COUNT,  3'd2, 27'h0, 32'h0);
        push_req(MODE_FIND,   3'd0, {3'd2, 24'd1}, 32'h0);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct <= (ph == 0) ? 11 : (ph == 1) ? 57 : 0;
            recv_idle_pct <= (ph == 0) ? 57 : (ph == 1) ? 11 : 0;
            for (int k = 0; k < 4; k++)
            begin
                apply_settings(max_list[ph * 4 + k], mask_list[ph * 4 + k]);
                for (int b = 0; b < 4; b++)
                begin
                    if (k == 1 && b == 2)
                        hold_req <= ~hold_req;
                    queue_random_batch(BATCH_ITEMS);
                    wait_drained();
                end
            end
        end

        repeat (30) @(posedge clk);
        $display("%0d results checked across %0d register settings and three idle profiles",
                 results_checked, settings_applied);
        $display("status mix: ok %0d, full %0d, not found %0d, bad type %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        if (fail_count == 0)
            $display("tb_typed_handle_table OK");
        else
            $display("tb_typed_handle_table NOT OK");
        $finish;
    end

endmodule
